### design/bsc_pkg.sv
// Shared types, constants and helper functions for the barometric compensation core.
`timescale 1ns / 1ps

package bsc_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CAL_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CAL_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIXED_CAL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HUM_CAL     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HUM_ENABLE  = 3'd5;

	// Stage counts of the datapath parts
	localparam int FINE_LAT  = 4;                       // raw temperature to fine temperature
	localparam int TEMP_LAT  = 5;                       // raw temperature to centi-degrees
	localparam int DIV_LAT   = 64;                      // one quotient bit per stage
	localparam int PRESS_LAT = 18 + DIV_LAT;            // fine temperature to pressure
	localparam int HUM_LAT   = 10;                      // fine temperature to humidity
	localparam int TOTAL_LAT = FINE_LAT + PRESS_LAT;    // word in to word out
	localparam int TEMP_DLY  = TOTAL_LAT - TEMP_LAT;
	localparam int HUM_DLY   = TOTAL_LAT - FINE_LAT - HUM_LAT;
	localparam int RAW_DLY   = FINE_LAT;

	// Output limits
	localparam logic [31:0] TEMP_MIN   = 32'hFFFF_0000;   // -65536
	localparam logic [31:0] TEMP_MAX   = 32'd65535;
	localparam logic [31:0] HUM_CLAMP  = 32'd419430400;
	localparam logic [16:0] HUM_MAX    = 17'd102400;

	typedef struct packed {
		logic [47:0] temp_cal;
		logic [63:0] press_cal_a;
		logic [63:0] press_cal_b;
		logic [47:0] mixed_cal;
		logic [39:0] hum_cal;
		logic        humidity_enable;
	} cal_t;

	function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned k);
		return 32'($signed(x) >>> k);
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned k);
		return 64'($signed(x) >>> k);
	endfunction

	function automatic logic [31:0] sx16_32(input logic [15:0] x);
		return {{16{x[15]}}, x};
	endfunction

	function automatic logic [31:0] sx8_32(input logic [7:0] x);
		return {{24{x[7]}}, x};
	endfunction

	function automatic logic [63:0] sx16_64(input logic [15:0] x);
		return {{48{x[15]}}, x};
	endfunction

	function automatic logic [63:0] sx32_64(input logic [31:0] x);
		return {{32{x[31]}}, x};
	endfunction

endpackage

### design/bsc_mul64.sv
// Two-stage 64x64 multiplier giving the low 64 bits, built from 32x32 partial products.
`timescale 1ns / 1ps

module bsc_mul64 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);
	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[31:0] * b[31:0];
			lh_s1 <= 32'(a[31:0] * b[63:32]);
			hl_s1 <= 32'(a[63:32] * b[31:0]);
			p     <= ll_s1 + {32'(lh_s1 + hl_s1), 32'd0};
		end
	end
endmodule

### design/bsc_div.sv
// Pipelined unsigned 64/64 restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module bsc_div (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] num,
	input  logic [63:0] den,
	input  logic [1:0]  side_in,
	output logic [63:0] quo,
	output logic [1:0]  side_out
);
	import bsc_pkg::*;

	logic [63:0] r_s  [DIV_LAT];
	logic [63:0] nq_s [DIV_LAT];
	logic [63:0] d_s  [DIV_LAT];
	logic [1:0]  sd_s [DIV_LAT];

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
		logic [63:0] r_in, nq_in, d_in;
		logic [1:0]  sd_in;
		logic [64:0] rs;
		logic        ge;

		if (k == 0) begin : g_first
			assign r_in  = 64'd0;
			assign nq_in = num;
			assign d_in  = den;
			assign sd_in = side_in;
		end else begin : g_next
			assign r_in  = r_s[k-1];
			assign nq_in = nq_s[k-1];
			assign d_in  = d_s[k-1];
			assign sd_in = sd_s[k-1];
		end

		assign rs = {r_in, nq_in[63]};
		assign ge = rs >= {1'b0, d_in};

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k]  <= ge ? 64'(rs - {1'b0, d_in}) : rs[63:0];
				nq_s[k] <= {nq_in[62:0], ge};
				d_s[k]  <= d_in;
				sd_s[k] <= sd_in;
			end
		end
	end

	assign quo      = nq_s[DIV_LAT-1];
	assign side_out = sd_s[DIV_LAT-1];
endmodule

### design/bsc_temp.sv
// Temperature path: fine temperature and saturated centi-degree output.
`timescale 1ns / 1ps

module bsc_temp (
	input  logic               clk,
	input  logic               en,
	input  logic [19:0]        raw,
	input  bsc_pkg::cal_t      cal,
	output logic [31:0]        fine,
	output logic [16:0]        temp
);
	import bsc_pkg::*;

	logic [31:0] t1, t2, t3;
	logic [31:0] a_s1, d_s1, m1_s2, dd_s2, v1_s3, m2_s3;
	logic [31:0] tx;
	logic [31:0] tc;

	assign t1 = {16'd0, cal.temp_cal[15:0]};
	assign t2 = sx16_32(cal.temp_cal[31:16]);
	assign t3 = sx16_32(cal.temp_cal[47:32]);

	// fine * 5 + 128, then >> 8 and saturate
	assign tx = asr32((fine << 2) + fine + 32'd128, 8);
	always_comb begin
		tc = tx;
		if ($signed(tx) < $signed(TEMP_MIN)) tc = TEMP_MIN;
		if ($signed(tx) > $signed(TEMP_MAX)) tc = TEMP_MAX;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= {15'd0, raw[19:3]} - {15'd0, t1[15:0], 1'b0};
			d_s1  <= {16'd0, raw[19:4]} - t1;
			m1_s2 <= a_s1 * t2;
			dd_s2 <= d_s1 * d_s1;
			v1_s3 <= asr32(m1_s2, 11);
			m2_s3 <= asr32(dd_s2, 12) * t3;
			fine  <= v1_s3 + asr32(m2_s3, 14);
			temp  <= tc[16:0];
		end
	end
endmodule

### design/bsc_hum.sv
// Humidity path: 32-bit wrapping datasheet formula, clamp and enable.
`timescale 1ns / 1ps

module bsc_hum (
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        raw,
	input  logic [31:0]        fine,
	input  bsc_pkg::cal_t      cal,
	output logic [16:0]        hum
);
	import bsc_pkg::*;

	logic [31:0] h1, h2, h3, h4, h5, h6;
	logic [31:0] x_s1, m5_s2, m6_s2, m3_s2, base_s2;
	logic [15:0] adc_s1;
	logic [31:0] a_s3, u_s3, w_s3, a_s4, b0_s4, a_s5, b1_s5, a_s6, b_s6;
	logic [31:0] x2_s7, x2_s8, ss_s8, x2_s9, t_s9;
	logic [31:0] s8, r10, c10;

	assign h1 = {24'd0, cal.mixed_cal[23:16]};
	assign h2 = sx16_32(cal.mixed_cal[39:24]);
	assign h3 = {24'd0, cal.mixed_cal[47:40]};
	assign h4 = sx16_32(cal.hum_cal[15:0]);
	assign h5 = sx16_32(cal.hum_cal[31:16]);
	assign h6 = sx8_32(cal.hum_cal[39:32]);

	assign s8  = asr32(x2_s7, 15);
	assign r10 = x2_s9 - asr32(t_s9, 4);
	always_comb begin
		c10 = r10;
		if (r10[31]) c10 = 32'd0;
		else if (r10 > HUM_CLAMP) c10 = HUM_CLAMP;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= fine - 32'd76800;
			adc_s1  <= raw;
			m5_s2   <= h5 * x_s1;
			m6_s2   <= x_s1 * h6;
			m3_s2   <= x_s1 * h3;
			base_s2 <= ({16'd0, adc_s1} << 14) - (h4 << 20) + 32'd16384;
			a_s3    <= asr32(base_s2 - m5_s2, 15);
			u_s3    <= asr32(m6_s2, 10);
			w_s3    <= asr32(m3_s2, 11) + 32'd32768;
			a_s4    <= a_s3;
			b0_s4   <= u_s3 * w_s3;
			a_s5    <= a_s4;
			b1_s5   <= (asr32(b0_s4, 10) + 32'd2097152) * h2;
			a_s6    <= a_s5;
			b_s6    <= asr32(b1_s5 + 32'd8192, 14);
			x2_s7   <= a_s6 * b_s6;
			x2_s8   <= x2_s7;
			ss_s8   <= s8 * s8;
			x2_s9   <= x2_s8;
			t_s9    <= asr32(ss_s8, 7) * h1;
			hum     <= cal.humidity_enable ? c10[28:12] : 17'd0;
		end
	end
endmodule

### design/bsc_press.sv
// Pressure path: 64-bit wrapping datasheet formula with pipelined signed division.
`timescale 1ns / 1ps

module bsc_press (
	input  logic               clk,
	input  logic               en,
	input  logic [19:0]        raw,
	input  logic [31:0]        fine,
	input  bsc_pkg::cal_t      cal,
	output logic [31:0]        press
);
	import bsc_pkg::*;

	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

	logic [63:0] v1_s1, p0_s1, p0_s2, p0_s3, p0_s4, p0_s5, p0_s6;
	logic [63:0] a_s3, c_s3, e_s3, c_s4, c_s5, e_s4, e_s5, b_s5, d_s5;
	logic [63:0] v2_s6, v1b_s6, n0_s7, v1b_s7, f_s9, n_s9, v1c_s10, n_s10;
	logic [63:0] an_s11, ad_s11, quo;
	logic        neg_s11, zero_s11;
	logic [1:0]  side;
	logic [63:0] q_s76, q_s77, q_s78, q_s79, q_s80, g_s77, g_s78;
	logic [63:0] h_s78, j_s78, j_s79, j_s80, i_s80, sum_s81;
	logic        zero_s76, zero_s77, zero_s78, zero_s79, zero_s80, zero_s81;

	assign p1 = {48'd0, cal.press_cal_a[15:0]};
	assign p2 = sx16_64(cal.press_cal_a[31:16]);
	assign p3 = sx16_64(cal.press_cal_a[47:32]);
	assign p4 = sx16_64(cal.press_cal_a[63:48]);
	assign p5 = sx16_64(cal.press_cal_b[15:0]);
	assign p6 = sx16_64(cal.press_cal_b[31:16]);
	assign p7 = sx16_64(cal.press_cal_b[47:32]);
	assign p8 = sx16_64(cal.press_cal_b[63:48]);
	assign p9 = sx16_64(cal.mixed_cal[15:0]);

	// v1*v1, v1*P5, v1*P2
	bsc_mul64 u_mul_a (.clk, .en, .a(v1_s1), .b(v1_s1), .p(a_s3));
	bsc_mul64 u_mul_c (.clk, .en, .a(v1_s1), .b(p5),    .p(c_s3));
	bsc_mul64 u_mul_e (.clk, .en, .a(v1_s1), .b(p2),    .p(e_s3));
	// v1^2*P6, v1^2*P3
	bsc_mul64 u_mul_b (.clk, .en, .a(a_s3),  .b(p6),    .p(b_s5));
	bsc_mul64 u_mul_d (.clk, .en, .a(a_s3),  .b(p3),    .p(d_s5));
	// divisor and dividend scaling
	bsc_mul64 u_mul_f (.clk, .en, .a(v1b_s7), .b(p1),          .p(f_s9));
	bsc_mul64 u_mul_n (.clk, .en, .a(n0_s7),  .b(64'd3125),    .p(n_s9));

	bsc_div u_div (
		.clk, .en,
		.num(an_s11), .den(ad_s11), .side_in({neg_s11, zero_s11}),
		.quo, .side_out(side)
	);

	// P9 * (p>>13) * (p>>13) and P8 * p
	bsc_mul64 u_mul_h (.clk, .en, .a(p9),    .b(asr64(q_s76, 13)), .p(h_s78));
	bsc_mul64 u_mul_j (.clk, .en, .a(p8),    .b(q_s76),            .p(j_s78));
	bsc_mul64 u_mul_i (.clk, .en, .a(h_s78), .b(g_s78),            .p(i_s80));

	always_ff @(posedge clk) begin
		if (en) begin
			v1_s1    <= sx32_64(fine) - 64'd128000;
			p0_s1    <= 64'd1048576 - {44'd0, raw};
			p0_s2    <= p0_s1;
			p0_s3    <= p0_s2;
			p0_s4    <= p0_s3;
			p0_s5    <= p0_s4;
			c_s4     <= c_s3;
			c_s5     <= c_s4;
			e_s4     <= e_s3;
			e_s5     <= e_s4;
			v2_s6    <= b_s5 + (c_s5 << 17) + (p4 << 35);
			v1b_s6   <= 64'h0000_8000_0000_0000 + asr64(d_s5, 8) + (e_s5 << 12);
			p0_s6    <= p0_s5;
			n0_s7    <= (p0_s6 << 31) - v2_s6;
			v1b_s7   <= v1b_s6;
			v1c_s10  <= asr64(f_s9, 33);
			n_s10    <= n_s9;
			neg_s11  <= n_s10[63] ^ v1c_s10[63];
			zero_s11 <= (v1c_s10 == 64'd0);
			an_s11   <= n_s10[63]   ? (~n_s10 + 64'd1)   : n_s10;
			ad_s11   <= v1c_s10[63] ? (~v1c_s10 + 64'd1) : v1c_s10;
			q_s76    <= side[1] ? (~quo + 64'd1) : quo;
			zero_s76 <= side[0];
			q_s77    <= q_s76;
			q_s78    <= q_s77;
			g_s77    <= asr64(q_s76, 13);
			g_s78    <= g_s77;
			zero_s77 <= zero_s76;
			zero_s78 <= zero_s77;
			j_s79    <= j_s78;
			j_s80    <= j_s79;
			q_s79    <= q_s78;
			q_s80    <= q_s79;
			zero_s79 <= zero_s78;
			zero_s80 <= zero_s79;
			sum_s81  <= q_s80 + asr64(i_s80, 25) + asr64(j_s80, 19);
			zero_s81 <= zero_s80;
			press    <= zero_s81 ? 32'd0 : 32'(asr64(sum_s81, 8) + (p7 << 4));
		end
	end
endmodule

### design/barometric_sensor_compensation_core.sv
// Throughput: one word per cycle while the output is not stalled; the pressure path
// (64 divider stages) sets the depth. A stalled output word freezes the whole
// pipeline until it is taken.
// Reset (arst_n low, asynchronous): all valid bits clear, calibration registers and
// humidity_enable return to zero; datapath registers are not reset.
`timescale 1ns / 1ps

module barometric_sensor_compensation_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [19:0]                       raw_pressure,
	input  logic [19:0]                       raw_temperature,
	input  logic [15:0]                       raw_humidity,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [16:0]                temperature_centi,
	output logic [31:0]                       pressure_q24_8,
	output logic [16:0]                       humidity_q22_10,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [63:0]                       cfg_data
);
	import bsc_pkg::*;

	cal_t                 cal_q;
	logic                 en;
	logic                 accept;
	logic [TOTAL_LAT-1:0] vld_q;

	// raw pressure/humidity wait for fine temperature
	logic [19:0] rp_d [RAW_DLY];
	logic [15:0] rh_d [RAW_DLY];
	// early results wait for the pressure path
	logic [16:0] temp_d [TEMP_DLY];
	logic [16:0] hum_d  [HUM_DLY];

	logic [31:0] fine;
	logic [16:0] temp_r;
	logic [16:0] hum_r;
	logic [31:0] press_r;

	// Config port always ready; user must make writes only while idle; not enforced here.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TEMP_CAL:    cal_q.temp_cal        <= cfg_data[47:0];
				CFG_PRESS_CAL_A: cal_q.press_cal_a     <= cfg_data;
				CFG_PRESS_CAL_B: cal_q.press_cal_b     <= cfg_data;
				CFG_MIXED_CAL:   cal_q.mixed_cal       <= cfg_data[47:0];
				CFG_HUM_CAL:     cal_q.hum_cal         <= cfg_data[39:0];
				CFG_HUM_ENABLE:  cal_q.humidity_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Global advance: everything moves unless the output word is held.
	assign en       = !(vld_q[TOTAL_LAT-1] && out_stall);
	assign in_stall = !en;
	assign accept   = in_valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rp_d[0] <= raw_pressure;
			rh_d[0] <= raw_humidity;
			for (int i = 1; i < RAW_DLY; i++) begin
				rp_d[i] <= rp_d[i-1];
				rh_d[i] <= rh_d[i-1];
			end
			temp_d[0] <= temp_r;
			for (int i = 1; i < TEMP_DLY; i++) begin
				temp_d[i] <= temp_d[i-1];
			end
			hum_d[0] <= hum_r;
			for (int i = 1; i < HUM_DLY; i++) begin
				hum_d[i] <= hum_d[i-1];
			end
		end
	end

	// Temperature first: it yields the fine temperature for the other two paths.
	bsc_temp u_temp (
		.clk, .en, .raw(raw_temperature), .cal(cal_q), .fine, .temp(temp_r)
	);

	bsc_hum u_hum (
		.clk, .en, .raw(rh_d[RAW_DLY-1]), .fine, .cal(cal_q), .hum(hum_r)
	);

	bsc_press u_press (
		.clk, .en, .raw(rp_d[RAW_DLY-1]), .fine, .cal(cal_q), .press(press_r)
	);

	assign out_valid         = vld_q[TOTAL_LAT-1];
	assign temperature_centi = $signed(temp_d[TEMP_DLY-1]);
	assign humidity_q22_10   = hum_d[HUM_DLY-1];
	assign pressure_q24_8    = press_r;

	// A held output word must back-pressure the input.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input not stalled while output word held");

	// Nothing waiting at the output: the input is open.
	a_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// An accepted word enters the first valid stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[0])
		else $error("accepted word lost at pipeline entry");

	// Humidity clamp upper limit.
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (humidity_q22_10 <= HUM_MAX))
		else $error("humidity beyond clamp");
endmodule
